[rtl/mhfnp_pkg.sv]
// Shared types, codes and constants for the hole-fill frame block.
package mhfnp_pkg;

  // Field and register widths.
  localparam int CHAN_W  = 8;
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 17;

  // Default frame store dimensions.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Size registers come out of reset at a full 256 x 256 frame.
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // The sweep counter sticks at all ones.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Command codes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // One stored pixel, blue in the low byte.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One result item.
  typedef struct packed {
    logic [COUNT_W-1:0] sweeps;
    logic               hole;
    pixel_t             pix;
  } result_t;

  // Status the fill sequencer hands back to the command logic.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] sweeps;
  } seq_status_t;

  // Neighbors in the order they are filled.
  typedef enum logic [1:0] {
    NB_BELOW,
    NB_ABOVE,
    NB_RIGHT,
    NB_LEFT
  } nb_t;

  // Command controller states.
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_READ,
    TOP_FILL
  } top_state_t;

  // Fill sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CENTER,
    SEQ_LOOK,
    SEQ_PEEL,
    SEQ_DONE
  } seq_state_t;

endpackage

[rtl/mhfnp_frame_mem.sv]
// Frame store: pixel and hole arrays with one write port and one registered read port.
module mhfnp_frame_mem #(
  parameter int ADDR_W = 16
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  mhfnp_pkg::pixel_t     wr_pixel,
  input  logic                  wr_hole,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output mhfnp_pkg::pixel_t     rd_pixel,
  output logic                  rd_hole
);
  import mhfnp_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  pixel_t pixel_mem [DEPTH];
  logic   hole_mem  [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pixel_mem[wr_addr] <= wr_pixel;
      hole_mem[wr_addr]  <= wr_hole;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pixel <= pixel_mem[rd_addr];
      rd_hole  <= hole_mem[rd_addr];
    end
  end

endmodule

[rtl/mhfnp_sweep_seq.sv]
// Fill sequencer: walks the frame column by column and peels opaque pixels into holes.
module mhfnp_sweep_seq #(
  parameter int COL_W = 8,
  parameter int ROW_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [COL_W:0]             aw,
  input  logic [ROW_W:0]             ah,
  input  mhfnp_pkg::pixel_t          rd_pixel,
  input  logic                       rd_hole,
  output logic                       rd_en,
  output logic [ROW_W+COL_W-1:0]     rd_addr,
  output logic                       wr_en,
  output logic [ROW_W+COL_W-1:0]     wr_addr,
  output mhfnp_pkg::pixel_t          wr_pixel,
  output logic                       wr_hole,
  output mhfnp_pkg::seq_status_t     status
);
  import mhfnp_pkg::*;

  localparam int ADDR_W = ROW_W + COL_W;

  seq_state_t          state, state_next;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  pixel_t              src;
  nb_t                 nb;
  logic                changed;
  logic [COUNT_W-1:0]  sweeps;

  logic [ROW_W:0]      row_plus;
  logic [COL_W:0]      col_plus;
  logic                last_row;
  logic                last_col;
  logic                opaque;
  logic                advance;
  logic                changed_now;
  logic                more_sweep;
  logic [ADDR_W-1:0]   nb_addr [4];
  logic                nb_ok   [4];
  nb_t                 nb_step;

  // Position arithmetic and neighbor addresses for the pixel being visited.
  assign row_plus = {1'b0, row} + 1'b1;
  assign col_plus = {1'b0, col} + 1'b1;
  assign last_row = (row_plus >= ah);
  assign last_col = (col_plus >= aw);
  assign opaque   = (rd_pixel.alpha != '0);
  assign nb_step  = nb_t'(nb + 2'd1);

  always_comb begin
    nb_addr[NB_BELOW] = {row_plus[ROW_W-1:0], col};
    nb_addr[NB_ABOVE] = {row - ROW_W'(1), col};
    nb_addr[NB_RIGHT] = {row, col_plus[COL_W-1:0]};
    nb_addr[NB_LEFT]  = {row, col - COL_W'(1)};
    nb_ok[NB_BELOW]   = !last_row;
    nb_ok[NB_ABOVE]   = (row != '0);
    nb_ok[NB_RIGHT]   = !last_col;
    nb_ok[NB_LEFT]    = (col != '0);
  end

  // A neighbor is written when it exists and its hole bit came back set.
  assign wr_en       = (state == SEQ_PEEL) && nb_ok[nb] && rd_hole;
  assign wr_addr     = nb_addr[nb];
  assign wr_pixel    = src;
  assign wr_hole     = 1'b0;

  assign advance     = ((state == SEQ_LOOK) && !opaque) ||
                       ((state == SEQ_PEEL) && (nb == NB_LEFT));
  assign changed_now = changed || wr_en;
  assign more_sweep  = !(last_row && last_col) || changed_now;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = ((aw == '0) || (ah == '0)) ? SEQ_DONE : SEQ_CENTER;
        end
      end
      SEQ_CENTER: state_next = SEQ_LOOK;
      SEQ_LOOK: begin
        if (!opaque) begin
          state_next = more_sweep ? SEQ_CENTER : SEQ_DONE;
        end else begin
          state_next = SEQ_PEEL;
        end
      end
      SEQ_PEEL: begin
        if (nb == NB_LEFT) begin
          state_next = more_sweep ? SEQ_CENTER : SEQ_DONE;
        end
      end
      SEQ_DONE: state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // Read requests: center pixel, then one neighbor probe per cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {row, col};
    unique case (state)
      SEQ_CENTER: rd_en = 1'b1;
      SEQ_LOOK: begin
        rd_en   = opaque;
        rd_addr = nb_addr[NB_BELOW];
      end
      SEQ_PEEL: begin
        rd_en   = (nb != NB_LEFT);
        rd_addr = nb_addr[nb_step];
      end
      default: rd_en = 1'b0;
    endcase
  end

  assign status.done   = (state == SEQ_DONE);
  assign status.sweeps = sweeps;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk position, change flag and sweep count.
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      nb      <= NB_BELOW;
      changed <= 1'b0;
      sweeps  <= '0;
    end else begin
      if ((state == SEQ_IDLE) && start) begin
        col     <= '0;
        row     <= '0;
        changed <= 1'b0;
        sweeps  <= COUNT_W'(1);
      end
      if (state == SEQ_LOOK) begin
        nb <= NB_BELOW;
      end
      if (state == SEQ_PEEL) begin
        nb <= nb_step;
        if (wr_en && !advance) begin
          changed <= 1'b1;
        end
      end
      // Moving to the next pixel carries the change flag along; the end of a
      // changed sweep clears it and starts over.
      if (advance) begin
        if (!last_row) begin
          row     <= row_plus[ROW_W-1:0];
          changed <= changed_now;
        end else if (!last_col) begin
          row     <= '0;
          col     <= col_plus[COL_W-1:0];
          changed <= changed_now;
        end else if (changed_now) begin
          row     <= '0;
          col     <= '0;
          changed <= 1'b0;
          if (sweeps != COUNT_MAX) begin
            sweeps <= sweeps + 1'b1;
          end
        end
      end
    end
  end

  // Source pixel is held for the neighbor writes.
  always_ff @(posedge clk) begin
    if (state == SEQ_LOOK) begin
      src <= rd_pixel;
    end
  end

endmodule

[rtl/mask_hole_fill_by_neighbor_peeling.sv]
// Top level: command decode, size registers, frame store and fill sequencer.
//
//   Channel   Signals                                        Direction
//   cfg       cfg_wr_en, cfg_index, cfg_data                 in
//   command   in_valid/in_ready, mode, column, row,
//             blue_in, green_in, red_in, alpha_in, hole_in   in
//   result    out_valid/out_ready, blue_out, green_out,
//             red_out, alpha_out, hole_out, sweep_count      out
//
// A read answers through the registered read port of the frame store. In each sweep
// a fill reads the center of every pixel and, for an opaque pixel, probes each
// neighbor for a hole in turn on the single read port.
// Reset is synchronous and clears the control state and the size registers to 256;
// the frame store is not cleared. A command is taken only while the controller is
// idle and the result register is empty or being emptied.
module mask_hole_fill_by_neighbor_peeling #(
  parameter int MAX_WIDTH  = mhfnp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mhfnp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [mhfnp_pkg::CFG_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [7:0]                     column,
  input  logic [7:0]                     row,
  input  logic [7:0]                     blue_in,
  input  logic [7:0]                     green_in,
  input  logic [7:0]                     red_in,
  input  logic [7:0]                     alpha_in,
  input  logic                           hole_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     blue_out,
  output logic [7:0]                     green_out,
  output logic [7:0]                     red_out,
  output logic [7:0]                     alpha_out,
  output logic                           hole_out,
  output logic [mhfnp_pkg::COUNT_W-1:0]  sweep_count
);
  import mhfnp_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int AW_W   = COL_W + 1;
  localparam int AH_W   = ROW_W + 1;

  top_state_t         state, state_next;
  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [AW_W-1:0]    aw;
  logic [AH_W-1:0]    ah;
  logic               accept_ok;
  logic               in_fire;
  logic               cmd_inside;
  logic               inside_q;
  logic [ADDR_W-1:0]  cmd_addr;
  pixel_t             cmd_pixel;

  logic               mem_wr_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  pixel_t             mem_wr_pixel;
  logic               mem_wr_hole;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  pixel_t             mem_rd_pixel;
  logic               mem_rd_hole;

  logic               seq_start;
  logic               seq_rd_en;
  logic [ADDR_W-1:0]  seq_rd_addr;
  logic               seq_wr_en;
  logic [ADDR_W-1:0]  seq_wr_addr;
  pixel_t             seq_wr_pixel;
  logic               seq_wr_hole;
  seq_status_t        seq_status;

  logic               out_load;
  result_t            out_data;
  result_t            out_q;

  // Size registers; the user is bound to write them only while the block is idle, unchecked by the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_RESET;
      image_height <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  // Active frame size, limited to the store.
  assign aw = (32'(image_width) >= 32'(MAX_WIDTH)) ? AW_W'(MAX_WIDTH) : AW_W'(image_width);
  assign ah = (32'(image_height) >= 32'(MAX_HEIGHT)) ? AH_W'(MAX_HEIGHT) : AH_W'(image_height);

  // Command position and pixel.
  assign cmd_inside = (32'(column) < 32'(aw)) && (32'(row) < 32'(ah));
  assign cmd_addr   = {ROW_W'(row), COL_W'(column)};
  assign cmd_pixel  = '{alpha: alpha_in, red: red_in, green: green_in, blue: blue_in};

  // Handshake on the command side.
  assign accept_ok = (state == TOP_IDLE) && (!out_valid || out_ready);
  assign in_ready  = accept_ok;
  assign in_fire   = in_valid && accept_ok;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      TOP_IDLE: begin
        if (in_fire && (mode == MODE_READ)) begin
          state_next = TOP_READ;
        end else if (in_fire && (mode == MODE_FILL)) begin
          state_next = TOP_FILL;
        end
      end
      TOP_READ: state_next = TOP_IDLE;
      TOP_FILL: begin
        if (seq_status.done) begin
          state_next = TOP_IDLE;
        end
      end
      default: state_next = TOP_IDLE;
    endcase
  end

  // Memory port selection, fill start and result loading.
  always_comb begin
    mem_wr_en    = 1'b0;
    mem_wr_addr  = cmd_addr;
    mem_wr_pixel = cmd_pixel;
    mem_wr_hole  = hole_in;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = cmd_addr;
    seq_start    = 1'b0;
    out_load     = 1'b0;
    out_data     = '0;
    unique case (state)
      TOP_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_WRITE: begin
              mem_wr_en = cmd_inside;
              out_load  = 1'b1;
            end
            MODE_READ:  mem_rd_en = 1'b1;
            MODE_FILL:  seq_start = 1'b1;
            default:    out_load  = 1'b1;
          endcase
        end
      end
      TOP_READ: begin
        out_load = 1'b1;
        if (inside_q) begin
          out_data.pix  = mem_rd_pixel;
          out_data.hole = mem_rd_hole;
        end
      end
      TOP_FILL: begin
        mem_wr_en       = seq_wr_en;
        mem_wr_addr     = seq_wr_addr;
        mem_wr_pixel    = seq_wr_pixel;
        mem_wr_hole     = seq_wr_hole;
        mem_rd_en       = seq_rd_en;
        mem_rd_addr     = seq_rd_addr;
        out_load        = seq_status.done;
        out_data.sweeps = seq_status.sweeps;
      end
      default: out_load = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TOP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload and the read's position check.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= out_data;
    end
    if (in_fire) begin
      inside_q <= cmd_inside;
    end
  end

  assign blue_out    = out_q.pix.blue;
  assign green_out   = out_q.pix.green;
  assign red_out     = out_q.pix.red;
  assign alpha_out   = out_q.pix.alpha;
  assign hole_out    = out_q.hole;
  assign sweep_count = out_q.sweeps;

  mhfnp_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_pixel (mem_wr_pixel),
    .wr_hole  (mem_wr_hole),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_pixel (mem_rd_pixel),
    .rd_hole  (mem_rd_hole)
  );

  mhfnp_sweep_seq #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_sweep_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (seq_start),
    .aw       (aw),
    .ah       (ah),
    .rd_pixel (mem_rd_pixel),
    .rd_hole  (mem_rd_hole),
    .rd_en    (seq_rd_en),
    .rd_addr  (seq_rd_addr),
    .wr_en    (seq_wr_en),
    .wr_addr  (seq_wr_addr),
    .wr_pixel (seq_wr_pixel),
    .wr_hole  (seq_wr_hole),
    .status   (seq_status)
  );

endmodule

[rtl/mhfnp_checker.sv]
// Port-level checks for the hole-fill block and the bind that attaches them.
module mhfnp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     blue_out,
  input  logic [7:0]                     green_out,
  input  logic [7:0]                     red_out,
  input  logic [7:0]                     alpha_out,
  input  logic                           hole_out,
  input  logic [mhfnp_pkg::COUNT_W-1:0]  sweep_count
);
  import mhfnp_pkg::*;

  // A command is only taken when the result register has room.
  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("command taken while the result register is full");

  // A fill result carries nothing but its sweep count.
  a_fill_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (sweep_count != '0)) |->
      ((blue_out == '0) && (green_out == '0) && (red_out == '0) &&
       (alpha_out == '0) && (hole_out == 1'b0)))
    else $error("fill result carries pixel data");

  // A write transaction answers in the next cycle with a zero sweep count, alpha and hole bit.
  a_write_answers: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode == MODE_WRITE)) |=>
      (out_valid && (sweep_count == '0) && (alpha_out == '0) && (hole_out == 1'b0)))
    else $error("write transaction did not answer at once");

  // A fill transaction blocks commands and cannot answer in the next cycle.
  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode == MODE_FILL)) |=> (!in_ready && !out_valid))
    else $error("fill transaction did not hold the block busy");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sweep_count) && $stable(alpha_out) && $stable(blue_out)))
    else $error("stalled result changed");

endmodule

bind mask_hole_fill_by_neighbor_peeling mhfnp_checker u_checker (.*);
